>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds at every edge, reset included.
`define FLP_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("flp check failed");

// Check that is off while reset is low.
`define FLP_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("flp check failed");

`endif

>>> rtl/flp_pkg.sv
package flp_pkg;

    localparam int FLP_FIRST_SECTOR     = 16;
    localparam int FLP_BYTES_PER_SECTOR = 4096;
    localparam int FLP_NUM_SECTORS      = 16;

    localparam int ADDR_W      = 23;
    localparam int REC_BYTES   = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = 32 / DIV_BITS;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [2:0] CMD_LOG   = 3'd0;
    localparam logic [2:0] CMD_SCAN  = 3'd1;
    localparam logic [2:0] CMD_PROBE = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_ERASE = 3'd1;
    localparam logic [2:0] ACT_READ  = 3'd2;
    localparam logic [2:0] ACT_PROBE = 3'd3;
    localparam logic [2:0] ACT_NONE  = 3'd4;

    typedef enum logic [1:0] {
        JOB_ONE,
        JOB_PAIR,
        JOB_CLEAR,
        JOB_READ
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [2:0]        action;
        logic [ADDR_W-1:0] addr;
        logic [63:0]       data;
        logic [31:0]       count;
        logic              bend;
        logic [ADDR_W-1:0] addr2;
        logic [31:0]       idx;
    } t_job;

    function automatic logic [ADDR_W-1:0] flp_sector_base(input int first, input int bps,
                                                           input int s);
        int p;
        p = (first + s) * bps;
        return p[ADDR_W-1:0];
    endfunction

endpackage

>>> rtl/flp_queue.sv
module flp_queue
    import flp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    output logic o_valid,
    output t_job o_data,
    input  logic i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (i_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/flp_front.sv
module flp_front
    import flp_pkg::*;
#(
    parameter int FIRST_SECTOR     = FLP_FIRST_SECTOR,
    parameter int BYTES_PER_SECTOR = FLP_BYTES_PER_SECTOR,
    parameter int NUM_SECTORS      = FLP_NUM_SECTORS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_accept,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_temperature_bits,
    input  logic [31:0] i_humidity_bits,
    input  logic        i_probe_erased,
    input  logic [31:0] i_record_index,
    input  logic        i_final_request,
    output t_job        o_job
);

    localparam int SEC_W    = $clog2(NUM_SECTORS + 1);
    localparam int OFF_W    = $clog2(BYTES_PER_SECTOR + REC_BYTES);
    localparam int CAPACITY = (BYTES_PER_SECTOR / REC_BYTES) * NUM_SECTORS;
    localparam logic [ADDR_W-1:0] BASE0 =
        flp_sector_base(FIRST_SECTOR, BYTES_PER_SECTOR, 0);

    logic              r_flash_ready;
    logic [ADDR_W-1:0] r_wr_addr,  n_wr_addr;
    logic [SEC_W-1:0]  r_sec,      n_sec;
    logic [OFF_W-1:0]  r_off,      n_off;
    logic [31:0]       r_total,    n_total;
    logic              r_scan,     n_scan;
    logic              r_wrapped,  n_wrapped;
    logic [SEC_W-1:0]  r_psec,     n_psec;
    logic [OFF_W-1:0]  r_poff,     n_poff;
    logic [ADDR_W-1:0] r_paddr,    n_paddr;

    logic [31:0]      cnt_inc;
    logic [OFF_W-1:0] off_inc;
    logic [OFF_W-1:0] poff_inc;
    logic [SEC_W-1:0] sec_inc;
    logic [SEC_W-1:0] psec_inc;
    t_job             job;

    assign cnt_inc  = (r_total == COUNT_MAX) ? r_total : r_total + 32'd1;
    assign off_inc  = r_off + OFF_W'(REC_BYTES);
    assign poff_inc = r_poff + OFF_W'(REC_BYTES);
    assign sec_inc  = r_sec + SEC_W'(1);
    assign psec_inc = r_psec + SEC_W'(1);
    assign o_job    = job;

    always_comb begin
        n_wr_addr = r_wr_addr;
        n_sec     = r_sec;
        n_off     = r_off;
        n_total   = r_total;
        n_scan    = r_scan;
        n_wrapped = r_wrapped;
        n_psec    = r_psec;
        n_poff    = r_poff;
        n_paddr   = r_paddr;
        job.kind   = JOB_ONE;
        job.action = ACT_NONE;
        job.addr   = '0;
        job.data   = '0;
        job.count  = r_total;
        job.bend   = 1'b0;
        job.addr2  = '0;
        job.idx    = '0;
        unique case (i_cmd)
            CMD_LOG: begin
                if (r_flash_ready && !r_scan) begin
                    job.action = ACT_WRITE;
                    job.addr   = r_wr_addr;
                    job.data   = {i_humidity_bits, i_temperature_bits};
                    job.count  = cnt_inc;
                    n_total    = cnt_inc;
                    if (off_inc >= OFF_W'(BYTES_PER_SECTOR)) begin
                        n_off = '0;
                        if (sec_inc == SEC_W'(NUM_SECTORS)) begin
                            n_sec     = '0;
                            n_wrapped = 1'b1;
                        end else begin
                            n_sec = sec_inc;
                        end
                        n_wr_addr = flp_sector_base(FIRST_SECTOR, BYTES_PER_SECTOR, int'(n_sec));
                        if (n_wrapped) begin
                            job.kind  = JOB_PAIR;
                            job.addr2 = n_wr_addr;
                        end
                    end else begin
                        n_off     = off_inc;
                        n_wr_addr = r_wr_addr + ADDR_W'(REC_BYTES);
                    end
                end
            end
            CMD_SCAN: begin
                n_sec     = '0;
                n_off     = '0;
                n_wr_addr = BASE0;
                n_total   = '0;
                n_scan    = 1'b0;
                n_wrapped = 1'b0;
                n_psec    = '0;
                n_poff    = '0;
                n_paddr   = BASE0;
                job.count = '0;
                if (r_flash_ready) begin
                    n_scan     = 1'b1;
                    job.action = ACT_PROBE;
                    job.addr   = BASE0;
                end
            end
            CMD_PROBE: begin
                if (r_scan) begin
                    if (i_probe_erased) begin
                        n_sec     = r_psec;
                        n_off     = r_poff;
                        n_wr_addr = r_paddr;
                        n_scan    = 1'b0;
                    end else if (poff_inc >= OFF_W'(BYTES_PER_SECTOR) &&
                                 psec_inc == SEC_W'(NUM_SECTORS)) begin
                        n_sec      = '0;
                        n_off      = '0;
                        n_wr_addr  = BASE0;
                        n_total    = 32'(CAPACITY);
                        n_scan     = 1'b0;
                        n_wrapped  = 1'b1;
                        job.action = ACT_ERASE;
                        job.addr   = BASE0;
                        job.count  = 32'(CAPACITY);
                    end else begin
                        if (poff_inc >= OFF_W'(BYTES_PER_SECTOR)) begin
                            n_psec  = psec_inc;
                            n_poff  = '0;
                            n_paddr = flp_sector_base(FIRST_SECTOR, BYTES_PER_SECTOR,
                                                      int'(psec_inc));
                        end else begin
                            n_poff  = poff_inc;
                            n_paddr = r_paddr + ADDR_W'(REC_BYTES);
                        end
                        n_total    = cnt_inc;
                        job.action = ACT_PROBE;
                        job.addr   = n_paddr;
                        job.count  = cnt_inc;
                    end
                end
            end
            CMD_CLEAR: begin
                n_sec      = '0;
                n_off      = '0;
                n_wr_addr  = BASE0;
                n_total    = '0;
                n_scan     = 1'b0;
                n_wrapped  = 1'b0;
                n_psec     = '0;
                n_poff     = '0;
                n_paddr    = BASE0;
                job.kind   = JOB_CLEAR;
                job.action = ACT_ERASE;
                job.count  = '0;
            end
            CMD_READ: begin
                job.bend = i_final_request;
                if (i_record_index < r_total) begin
                    job.kind   = JOB_READ;
                    job.action = ACT_READ;
                    job.idx    = i_record_index;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_ready <= 1'b0;
            r_wr_addr     <= BASE0;
            r_sec         <= '0;
            r_off         <= '0;
            r_total       <= '0;
            r_scan        <= 1'b0;
            r_wrapped     <= 1'b0;
            r_psec        <= '0;
            r_poff        <= '0;
            r_paddr       <= BASE0;
        end else begin
            if (i_cfg_we) begin
                r_flash_ready <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_wr_addr <= n_wr_addr;
                r_sec     <= n_sec;
                r_off     <= n_off;
                r_total   <= n_total;
                r_scan    <= n_scan;
                r_wrapped <= n_wrapped;
                r_psec    <= n_psec;
                r_poff    <= n_poff;
                r_paddr   <= n_paddr;
            end
        end
    end

endmodule

>>> rtl/flp_back.sv
module flp_back
    import flp_pkg::*;
#(
    parameter int FIRST_SECTOR     = FLP_FIRST_SECTOR,
    parameter int BYTES_PER_SECTOR = FLP_BYTES_PER_SECTOR,
    parameter int NUM_SECTORS      = FLP_NUM_SECTORS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  t_job              i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_action,
    output logic [ADDR_W-1:0] o_flash_addr,
    output logic [63:0]       o_record_data,
    output logic [31:0]       o_stored_count,
    output logic              o_batch_end,
    output logic              o_last
);

    localparam int CAPACITY = (BYTES_PER_SECTOR / REC_BYTES) * NUM_SECTORS;
    localparam int CAP_W    = $clog2(CAPACITY);
    localparam int REM_W    = CAP_W + 1;
    localparam bit CAP_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
    localparam int STEP_MAX = (NUM_SECTORS > DIV_STEPS) ? NUM_SECTORS : DIV_STEPS;
    localparam int STEP_W   = $clog2(STEP_MAX + 1);
    localparam logic [ADDR_W-1:0] BASE0 =
        flp_sector_base(FIRST_SECTOR, BYTES_PER_SECTOR, 0);

    logic [STEP_W-1:0] r_step;
    logic [ADDR_W-1:0] r_run_addr;
    logic [REM_W-1:0]  r_rem,     n_rem;
    logic [31:0]       r_div_idx, n_div_idx;
    logic              r_ov;
    logic [2:0]        r_action;
    logic [ADDR_W-1:0] r_addr;
    logic [63:0]       r_data;
    logic [31:0]       r_count;
    logic              r_bend;
    logic              r_last;

    logic              out_free;
    logic              emit;
    logic              div_go;
    logic [2:0]        res_action;
    logic [ADDR_W-1:0] res_addr;
    logic [63:0]       res_data;
    logic              res_last;
    logic [ADDR_W-1:0] clr_addr;
    logic [REM_W-1:0]  rem_t;

    assign out_free = !r_ov || !i_out_stall;
    assign clr_addr = (r_step == '0) ? BASE0 : r_run_addr;

    // remainder of the record index by the capacity, DIV_BITS bits a cycle
    always_comb begin
        n_rem     = (r_step == '0) ? '0 : r_rem;
        n_div_idx = (r_step == '0) ? i_job.idx : r_div_idx;
        for (int j = 0; j < DIV_BITS; j++) begin
            rem_t     = {n_rem[CAP_W-1:0], n_div_idx[31]};
            n_div_idx = {n_div_idx[30:0], 1'b0};
            if (rem_t >= REM_W'(CAPACITY)) begin
                rem_t = rem_t - REM_W'(CAPACITY);
            end
            n_rem = rem_t;
        end
    end

    always_comb begin
        emit       = 1'b0;
        o_pop      = 1'b0;
        div_go     = 1'b0;
        res_action = i_job.action;
        res_addr   = i_job.addr;
        res_data   = i_job.data;
        res_last   = 1'b1;
        if (i_job_valid) begin
            unique case (i_job.kind)
                JOB_ONE: begin
                    emit  = out_free;
                    o_pop = emit;
                end
                JOB_PAIR: begin
                    emit = out_free;
                    if (r_step == '0) begin
                        res_last = 1'b0;
                    end else begin
                        res_action = ACT_ERASE;
                        res_addr   = i_job.addr2;
                        res_data   = '0;
                        o_pop      = emit;
                    end
                end
                JOB_CLEAR: begin
                    emit     = out_free;
                    res_addr = clr_addr;
                    res_last = (r_step == STEP_W'(NUM_SECTORS - 1));
                    o_pop    = emit && res_last;
                end
                JOB_READ: begin
                    if (CAP_POW2) begin
                        res_addr = BASE0 + (ADDR_W'(i_job.idx[CAP_W-1:0]) << 3);
                        emit     = out_free;
                        o_pop    = emit;
                    end else if (r_step == STEP_W'(DIV_STEPS)) begin
                        res_addr = BASE0 + (ADDR_W'(r_rem[CAP_W-1:0]) << 3);
                        emit     = out_free;
                        o_pop    = emit;
                    end else begin
                        div_go = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_step <= '0;
            end else if (emit || div_go) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_run_addr <= clr_addr + ADDR_W'(BYTES_PER_SECTOR);
            r_action   <= res_action;
            r_addr     <= res_addr;
            r_data     <= res_data;
            r_count    <= i_job.count;
            r_bend     <= i_job.bend;
            r_last     <= res_last;
        end
        if (div_go) begin
            r_rem     <= n_rem;
            r_div_idx <= n_div_idx;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_action       = r_action;
    assign o_flash_addr   = r_addr;
    assign o_record_data  = r_data;
    assign o_stored_count = r_count;
    assign o_batch_end    = r_bend;
    assign o_last         = r_last;

endmodule

>>> rtl/flash_circular_log_pointer.sv
// Channel   Direction  Handshake                  Payload
// command   in         i_in_valid / o_in_stall    i_cmd, i_temperature_bits, i_humidity_bits,
//                                                 i_probe_erased, i_record_index,
//                                                 i_final_request
// result    out        o_out_valid / i_out_stall  o_action, o_flash_addr, o_record_data,
//                                                 o_stored_count, o_batch_end, o_last
// config    in         i_cfg_we                   i_cfg_wdata (flash_ready)
//
// One command beat a cycle while the two-entry job queue has room; state updates at accept.
// Single-result beats enter the output register from the queue head when it has room; clear all
// gives NUM_SECTORS results one a cycle unless stalled; a wrapped sector change adds an erase.
// Reads use the index directly for a power-of-two capacity, else the remainder unit.
// Synchronous active-low reset clears pointer, count, scan and wrap flags and flash_ready.
// o_in_stall rises only on a full queue; a result stalled by i_out_stall holds.
module flash_circular_log_pointer
    import flp_pkg::*;
#(
    parameter int FIRST_SECTOR     = FLP_FIRST_SECTOR,
    parameter int BYTES_PER_SECTOR = FLP_BYTES_PER_SECTOR,
    parameter int NUM_SECTORS      = FLP_NUM_SECTORS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_temperature_bits,
    input  logic [31:0] i_humidity_bits,
    input  logic        i_probe_erased,
    input  logic [31:0] i_record_index,
    input  logic        i_final_request,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_action,
    output logic [22:0] o_flash_addr,
    output logic [63:0] o_record_data,
    output logic [31:0] o_stored_count,
    output logic        o_batch_end,
    output logic        o_last
);

    logic accept;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_job f_job;
    t_job q_job;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    flp_front #(
        .FIRST_SECTOR     (FIRST_SECTOR),
        .BYTES_PER_SECTOR (BYTES_PER_SECTOR),
        .NUM_SECTORS      (NUM_SECTORS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_accept           (accept),
        .i_cmd              (i_cmd),
        .i_temperature_bits (i_temperature_bits),
        .i_humidity_bits    (i_humidity_bits),
        .i_probe_erased     (i_probe_erased),
        .i_record_index     (i_record_index),
        .i_final_request    (i_final_request),
        .o_job              (f_job)
    );

    flp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_job),
        .i_pop   (q_pop)
    );

    flp_back #(
        .FIRST_SECTOR     (FIRST_SECTOR),
        .BYTES_PER_SECTOR (BYTES_PER_SECTOR),
        .NUM_SECTORS      (NUM_SECTORS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (q_job),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_action       (o_action),
        .o_flash_addr   (o_flash_addr),
        .o_record_data  (o_record_data),
        .o_stored_count (o_stored_count),
        .o_batch_end    (o_batch_end),
        .o_last         (o_last)
    );

endmodule

>>> rtl/flp_chk.sv
`include "assert_macros.svh"

module flp_chk
    import flp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_action,
    input logic [22:0] o_flash_addr,
    input logic [63:0] o_record_data,
    input logic        o_batch_end,
    input logic        o_last
);

    `FLP_ASSERT(a_rst_idle, i_clk, !i_rst_n |=> !o_out_valid)
    `FLP_ASSERT_RST(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_action) && $stable(o_flash_addr))
    `FLP_ASSERT_RST(a_data_zero, i_clk, i_rst_n, o_out_valid && o_action != ACT_WRITE |-> o_record_data == 64'd0)
    `FLP_ASSERT_RST(a_none_single, i_clk, i_rst_n, o_out_valid && o_action == ACT_NONE |-> o_flash_addr == 23'd0 && o_last)
    `FLP_ASSERT_RST(a_bend_read, i_clk, i_rst_n, o_out_valid && o_batch_end |-> o_last && (o_action == ACT_READ || o_action == ACT_NONE))

endmodule

bind flash_circular_log_pointer flp_chk u_chk (.*);
